// ===== hw/rtl/pscp_pkg.sv =====
// Shared constants and register codes for the point to segment closest point block.
package pscp_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int ADDR_WIDTH      = 4;
	localparam int DATA_WIDTH      = 32;

	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_DIR_X   = 2'd2,
		REG_DIR_Y   = 2'd3
	} reg_idx_t;

endpackage

// ===== hw/rtl/point_segment_closest_point.sv =====
// Closest point on a segment to a query point: pipelined projection and clamp.
//
//   channel  | handshake                 | payload
//   point    | point_valid, point_stall  | point_x, point_y
//   result   | result_valid, result_stall| closest_off_x/y, gap_x/y, corner_hit
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One item per cycle while no stalled result holds the pipeline; the radix-2 divider
// retires one quotient bit per stage.
// arst_n clears all valid bits and the segment registers.
// A stalled result holds the whole pipeline; point_stall follows it directly.
module point_segment_closest_point #(
	parameter int COORD_WIDTH = pscp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pscp_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [pscp_pkg::DATA_WIDTH-1:0]     pwdata,
	output logic [pscp_pkg::DATA_WIDTH-1:0]     prdata,
	output logic                                pready,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic signed [COORD_WIDTH-1:0]       point_x,
	input  logic signed [COORD_WIDTH-1:0]       point_y,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [COORD_WIDTH-1:0]       closest_off_x,
	output logic signed [COORD_WIDTH-1:0]       closest_off_y,
	output logic signed [COORD_WIDTH-1:0]       gap_x,
	output logic signed [COORD_WIDTH-1:0]       gap_y,
	output logic                                corner_hit
);

	localparam int W    = COORD_WIDTH;
	localparam int QW   = W + 1;
	localparam int PW   = 2 * W + 1;
	localparam int DOTW = 2 * W + 2;
	localparam int DENW = 2 * W;
	localparam int RW   = 2 * W + 1;
	localparam int GW   = W + 2;

	typedef struct packed {
		logic signed [QW-1:0]  qx;
		logic signed [QW-1:0]  qy;
		logic signed [W-1:0]   dx;
		logic signed [W-1:0]   dy;
		logic [W-1:0]          mx;
		logic [W-1:0]          my;
		logic [DENW-1:0]       den;
		logic [RW-1:0]         dotv;
		logic [RW-1:0]         rx;
		logic [RW-1:0]         ry;
		logic [W-1:0]          quo_x;
		logic [W-1:0]          quo_y;
		logic                  corner;
		logic                  over;
	} div_t;

	logic signed [W-1:0] sx_q, sy_q, dx_q, dy_q;
	logic                en;

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [QW-1:0] qx_s1, qy_s1, qx_s2, qy_s2, qx_s3, qy_s3;
	logic signed [W-1:0]  dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic signed [PW-1:0] pxx_s2, pyy_s2;
	logic [DENW-1:0]      dxx_s2, dyy_s2, den_s3;
	logic signed [DOTW-1:0] dot_s3;
	logic [W-1:0]         mdx_s1, mdy_s1, mdx_s3, mdy_s3;

	logic                 vld_sd [0:W];
	div_t                 pl_sd  [0:W];
	div_t                 nxt_sd [0:W-1];
	div_t                 ent;

	logic signed [W-1:0]  ox, oy;
	logic signed [GW-1:0] gx, gy, gmax, gmin;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (pscp_pkg::reg_idx_t'(paddr[3:2]))
				pscp_pkg::REG_START_X: sx_q <= pwdata[W-1:0];
				pscp_pkg::REG_START_Y: sy_q <= pwdata[W-1:0];
				pscp_pkg::REG_DIR_X:   dx_q <= pwdata[W-1:0];
				pscp_pkg::REG_DIR_Y:   dy_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (pscp_pkg::reg_idx_t'(paddr[3:2]))
			pscp_pkg::REG_START_X: prdata = pscp_pkg::DATA_WIDTH'(sx_q);
			pscp_pkg::REG_START_Y: prdata = pscp_pkg::DATA_WIDTH'(sy_q);
			pscp_pkg::REG_DIR_X:   prdata = pscp_pkg::DATA_WIDTH'(dx_q);
			pscp_pkg::REG_DIR_Y:   prdata = pscp_pkg::DATA_WIDTH'(dy_q);
			default:               prdata = '0;
		endcase
	end

	// flow control
	assign en          = !result_valid || !result_stall;
	assign point_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign mdx_s1 = dx_s1[W-1] ? W'(-dx_s1) : W'(dx_s1);
	assign mdy_s1 = dy_s1[W-1] ? W'(-dy_s1) : W'(dy_s1);
	assign mdx_s3 = dx_s3[W-1] ? W'(-dx_s3) : W'(dx_s3);
	assign mdy_s3 = dy_s3[W-1] ? W'(-dy_s3) : W'(dy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1  <= QW'(point_x) - QW'(sx_q);
			qy_s1  <= QW'(point_y) - QW'(sy_q);
			dx_s1  <= dx_q;
			dy_s1  <= dy_q;

			pxx_s2 <= PW'(qx_s1) * PW'(dx_s1);
			pyy_s2 <= PW'(qy_s1) * PW'(dy_s1);
			dxx_s2 <= DENW'(mdx_s1) * DENW'(mdx_s1);
			dyy_s2 <= DENW'(mdy_s1) * DENW'(mdy_s1);
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;

			dot_s3 <= DOTW'(pxx_s2) + DOTW'(pyy_s2);
			den_s3 <= dxx_s2 + dyy_s2;
			qx_s3  <= qx_s2;
			qy_s3  <= qy_s2;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
		end
	end

	// classify and load the divider
	always_comb begin
		logic neg, zero, over;
		neg  = dot_s3[DOTW-1];
		zero = (den_s3 == '0);
		over = !neg && !zero && ($unsigned(dot_s3) > DOTW'(den_s3));
		ent        = '0;
		ent.qx     = qx_s3;
		ent.qy     = qy_s3;
		ent.dx     = dx_s3;
		ent.dy     = dy_s3;
		ent.mx     = mdx_s3;
		ent.my     = mdy_s3;
		ent.den    = den_s3;
		ent.over   = over;
		ent.corner = neg || zero || over;
		ent.dotv   = ent.corner ? '0 : RW'(dot_s3[DENW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_sd[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_sd[0] <= ent;
		end
	end

	// one quotient bit per stage, digit 0, 1 or 2
	for (genvar i = 0; i < W; i++) begin : g_div
		always_comb begin
			logic [RW-1:0] d1, d2, tx, ty;
			d1 = RW'(pl_sd[i].den);
			d2 = {pl_sd[i].den, 1'b0};
			tx = {pl_sd[i].rx[RW-2:0], 1'b0} + (pl_sd[i].mx[W-1-i] ? pl_sd[i].dotv : '0);
			ty = {pl_sd[i].ry[RW-2:0], 1'b0} + (pl_sd[i].my[W-1-i] ? pl_sd[i].dotv : '0);
			nxt_sd[i] = pl_sd[i];
			if (tx >= d2) begin
				nxt_sd[i].rx    = tx - d2;
				nxt_sd[i].quo_x = {pl_sd[i].quo_x[W-2:0], 1'b0} + W'(2);
			end else if (tx >= d1) begin
				nxt_sd[i].rx    = tx - d1;
				nxt_sd[i].quo_x = {pl_sd[i].quo_x[W-2:0], 1'b0} + W'(1);
			end else begin
				nxt_sd[i].rx    = tx;
				nxt_sd[i].quo_x = {pl_sd[i].quo_x[W-2:0], 1'b0};
			end
			if (ty >= d2) begin
				nxt_sd[i].ry    = ty - d2;
				nxt_sd[i].quo_y = {pl_sd[i].quo_y[W-2:0], 1'b0} + W'(2);
			end else if (ty >= d1) begin
				nxt_sd[i].ry    = ty - d1;
				nxt_sd[i].quo_y = {pl_sd[i].quo_y[W-2:0], 1'b0} + W'(1);
			end else begin
				nxt_sd[i].ry    = ty;
				nxt_sd[i].quo_y = {pl_sd[i].quo_y[W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i+1] <= 1'b0;
			end else if (en) begin
				vld_sd[i+1] <= vld_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_sd[i+1] <= nxt_sd[i];
			end
		end
	end

	// select offset, form and saturate the gap
	assign gmax = {3'b000, {(W-1){1'b1}}};
	assign gmin = {3'b111, {(W-1){1'b0}}};

	always_comb begin
		if (pl_sd[W].corner) begin
			ox = pl_sd[W].over ? pl_sd[W].dx : '0;
			oy = pl_sd[W].over ? pl_sd[W].dy : '0;
		end else begin
			ox = pl_sd[W].dx[W-1] ? -$signed(pl_sd[W].quo_x) : $signed(pl_sd[W].quo_x);
			oy = pl_sd[W].dy[W-1] ? -$signed(pl_sd[W].quo_y) : $signed(pl_sd[W].quo_y);
		end
		gx = GW'(pl_sd[W].qx) - GW'(ox);
		gy = GW'(pl_sd[W].qy) - GW'(oy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= vld_sd[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			closest_off_x <= ox;
			closest_off_y <= oy;
			gap_x         <= (gx > gmax) ? gmax[W-1:0] : ((gx < gmin) ? gmin[W-1:0] : gx[W-1:0]);
			gap_y         <= (gy > gmax) ? gmax[W-1:0] : ((gy < gmin) ? gmin[W-1:0] : gy[W-1:0]);
			corner_hit    <= pl_sd[W].corner;
		end
	end

`ifndef SYNTH
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall == (result_valid && result_stall))
		else $error("point_stall out of step with result side");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_sd[W]) |=> result_valid)
		else $error("item lost at result register");

	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[W] && !pl_sd[W].corner) |-> (pl_sd[W].rx < RW'(pl_sd[W].den)))
		else $error("divider remainder x not below divisor");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[W] && !pl_sd[W].corner) |-> (pl_sd[W].ry < RW'(pl_sd[W].den)))
		else $error("divider remainder y not below divisor");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[W] && !pl_sd[W].corner) |->
			(pl_sd[W].quo_x <= pl_sd[W].mx) && (pl_sd[W].quo_y <= pl_sd[W].my))
		else $error("projection exceeds direction");
`endif

endmodule

// ===== tb/tb_point_segment_closest_point.sv =====
// Self-checking testbench for the point to segment closest point block.
`timescale 1ns / 1ps

module tb_point_segment_closest_point;

	localparam int W = 24;
	localparam int LATENCY = W + 5;
	localparam int LIMIT = 2000000;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic signed [W-1:0] off_x;
		logic signed [W-1:0] off_y;
		logic signed [W-1:0] gap_x;
		logic signed [W-1:0] gap_y;
		logic corner;
	} closest_t;

	class closest_board;
		logic signed [W-1:0] start_x, start_y, dir_x, dir_y;
		closest_t pending[$];
		int errors;

		function void set_reg(pscp_pkg::reg_idx_t idx, logic [W-1:0] v);
			case (idx)
				pscp_pkg::REG_START_X: start_x = v;
				pscp_pkg::REG_START_Y: start_y = v;
				pscp_pkg::REG_DIR_X:   dir_x = v;
				pscp_pkg::REG_DIR_Y:   dir_y = v;
				default: ;
			endcase
		endfunction

		function logic signed [W-1:0] clip(logic signed [W+1:0] v);
			if (v > CMAX) return CMAX;
			if (v < CMIN) return CMIN;
			return v[W-1:0];
		endfunction

		function void note_point(logic signed [W-1:0] px, logic signed [W-1:0] py);
			logic signed [W:0] qx, qy;
			logic signed [127:0] dot, den, nx, ny;
			closest_t c;
			qx = px - start_x;
			qy = py - start_y;
			den = dir_x * dir_x + dir_y * dir_y;
			dot = qx * dir_x + qy * dir_y;
			c = '0;
			if (den == 0 || dot < 0) begin
				c.corner = 1'b1;
			end else if (dot > den) begin
				c.off_x = dir_x;
				c.off_y = dir_y;
				c.corner = 1'b1;
			end else begin
				nx = dot * dir_x;
				ny = dot * dir_y;
				c.off_x = W'(nx / den);
				c.off_y = W'(ny / den);
			end
			c.gap_x = clip(qx - c.off_x);
			c.gap_y = clip(qy - c.off_y);
			pending.push_back(c);
		endfunction

		function void check(closest_t got);
			closest_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.off_x !== e.off_x)
				$display("%0t off_x exp %0d got %0d", $time, e.off_x, got.off_x);
			if (got.off_y !== e.off_y)
				$display("%0t off_y exp %0d got %0d", $time, e.off_y, got.off_y);
			if (got.gap_x !== e.gap_x)
				$display("%0t gap_x exp %0d got %0d", $time, e.gap_x, got.gap_x);
			if (got.gap_y !== e.gap_y)
				$display("%0t gap_y exp %0d got %0d", $time, e.gap_y, got.gap_y);
			if (got.corner !== e.corner)
				$display("%0t corner exp %0d got %0d", $time, e.corner, got.corner);
			if (got !== e) errors++;
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [pscp_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [pscp_pkg::DATA_WIDTH-1:0] pwdata = '0, prdata;
	logic pready;
	logic point_valid = 0, point_stall;
	logic signed [W-1:0] point_x = '0, point_y = '0;
	logic result_valid, result_stall = 0, corner_hit;
	logic signed [W-1:0] closest_off_x, closest_off_y, gap_x, gap_y;

	closest_board board = new();
	int send_idle = 0, stall_pct = 0;
	longint cycles = 0;

	always #6 clk = ~clk;

	point_segment_closest_point #(.COORD_WIDTH(W)) uut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && result_valid && !result_stall)
			board.check({closest_off_x, closest_off_y, gap_x, gap_y, corner_hit});
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic write_reg(pscp_pkg::reg_idx_t idx, logic signed [W-1:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= pscp_pkg::ADDR_WIDTH'(4 * idx);
		pwdata <= {{(pscp_pkg::DATA_WIDTH-W){v[W-1]}}, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.set_reg(idx, v);
	endtask

	task automatic set_segment(logic signed [W-1:0] sx, sy, dx, dy);
		write_reg(pscp_pkg::REG_START_X, sx);
		write_reg(pscp_pkg::REG_START_Y, sy);
		write_reg(pscp_pkg::REG_DIR_X, dx);
		write_reg(pscp_pkg::REG_DIR_Y, dy);
	endtask

	task automatic send_point(logic signed [W-1:0] x, y);
		while ($urandom_range(99) < send_idle) begin
			point_valid <= 0;
			@(posedge clk);
		end
		point_valid <= 1;
		point_x <= x;
		point_y <= y;
		@(posedge clk);
		while (point_stall) @(posedge clk);
		board.note_point(x, y);
	endtask

	task automatic drain();
		point_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [W-1:0] rnd_coord(int scale);
		logic signed [W-1:0] v;
		v = W'($urandom);
		case (scale)
			0: return v;
			1: return v >>> 8;
			default: return v >>> 14;
		endcase
	endfunction

	initial begin
		logic signed [W-1:0] q[6];
		logic signed [W-1:0] sx, sy, dx, dy, px, py;
		int sc;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		q = '{CMIN, CMAX, 0, -1, 1, 24'sh000100};
		// zero direction, then extremes of every field
		send_point(CMAX, CMIN);
		send_point(0, 0);
		drain();
		set_segment(CMIN, CMAX, CMAX, CMIN);
		foreach (q[i]) send_point(q[i], q[5 - i]);
		drain();
		set_segment(0, 0, 24'sh000a00, 24'sh000500);
		send_point(-24'sh100, 0);
		send_point(24'sh5000, 24'sh3000);
		send_point(24'sh500, 24'sh200);
		send_point(24'sh400, -24'sh300);
		send_point(24'sh0a00, 24'sh0500);
		send_point(0, 0);
		drain();
		set_segment(CMAX, CMIN, CMIN, CMIN);
		foreach (q[i]) send_point(q[i], q[i]);
		drain();
		for (int ph = 0; ph < 20; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 72; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 72; end
				default: begin send_idle = 36; stall_pct = 36; end
			endcase
			sc = ph % 3;
			sx = rnd_coord(sc); sy = rnd_coord(sc);
			dx = rnd_coord(sc); dy = rnd_coord(sc);
			if (ph == 7) begin dx = 0; dy = 0; end
			if (ph == 11) begin dx = CMIN; dy = CMAX; end
			set_segment(sx, sy, dx, dy);
			for (int n = 0; n < 78; n++) begin
				if ($urandom_range(3) == 0) begin
					px = rnd_coord(0); py = rnd_coord(0);
				end else begin
					px = W'(longint'(sx)
						+ ((longint'(dx) * longint'($urandom_range(1200))) / 1000)
						+ longint'(rnd_coord(sc) >>> 2));
					py = W'(longint'(sy)
						+ ((longint'(dy) * longint'($urandom_range(1200))) / 1000)
						+ longint'(rnd_coord(sc) >>> 2));
				end
				send_point(px, py);
			end
			drain();
		end
		stall_pct = 0;
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/pscp_pkg.sv
hw/rtl/point_segment_closest_point.sv
tb/tb_point_segment_closest_point.sv
